>>> rtl/core/ctw_pkg.sv
// ----------------------------------------------------------------------------
// ctw_pkg: shared types and constants of the text console writer
// Screen geometry, cell codes, operation codes, controller states and the
// request bundle that drives the cell memory.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ctw_pkg;

  // Screen geometry
  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int COPY_COUNT = CELL_COUNT - COLUMNS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int CNT_W      = $clog2(CELL_COUNT + 1);

  // Field widths
  localparam int OP_W   = 3;
  localparam int CHAR_W = 8;
  localparam int COLR_W = 4;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 6;
  localparam int ATTR_W = 8;
  localparam int CELL_W = 16;

  // Bounds in the widths used for compares
  localparam logic [COL_W:0]   COLUMNS_C = (COL_W + 1)'(COLUMNS);
  localparam logic [ROW_W:0]   ROWS_C    = (ROW_W + 1)'(ROWS);
  localparam logic [ROW_W-1:0] LAST_ROW  = ROW_W'(ROWS - 1);

  // Cell codes
  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
  localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
  localparam logic [ATTR_W-1:0] DEFAULT_ATTR = 8'h07;
  localparam logic [CELL_W-1:0] BLANK_CELL   = {DEFAULT_ATTR, BLANK_CHAR};

  typedef enum logic [OP_W-1:0] {
    OP_WRITE_CHAR = 3'd0,
    OP_SET_CURSOR = 3'd1,
    OP_CLEAR      = 3'd2,
    OP_SET_COLOR  = 3'd3,
    OP_READ_CELL  = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_RDWAIT,
    ST_SCROLL,
    ST_CLEAR
  } state_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CELL_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

`default_nettype wire

>>> rtl/core/text_console_writer_top.sv
// ----------------------------------------------------------------------------
// text_console_writer_top: text-mode console engine
// Character cell store with cursor, attribute, wrap, scroll and clear.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its single result
// appears for one cycle with done high and cannot be held off. A character
// write, set cursor, set colour or unused code passes through the execute
// state only; an on-screen cell read adds a wait state for the memory's
// registered read. A write or newline that runs past the last row scrolls the
// store through the cell memory, one cell a cycle. Clear screen sweeps the
// memory the same way. After reset the block clears the store, busy high,
// before taking a request.
`timescale 1ns / 1ps
`default_nettype none

module text_console_writer_top (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [ctw_pkg::OP_W-1:0]      op,
  input  wire logic [ctw_pkg::CHAR_W-1:0]    char_code,
  input  wire logic [ctw_pkg::COLR_W-1:0]    fg_color,
  input  wire logic [ctw_pkg::COLR_W-1:0]    bg_color,
  input  wire logic [ctw_pkg::COL_W-1:0]     cell_col,
  input  wire logic [ctw_pkg::ROW_W-1:0]     cell_row,
  output logic                               done,
  output logic     [ctw_pkg::CELL_W-1:0]     cell_data,
  output logic     [ctw_pkg::COL_W-1:0]      cursor_col,
  output logic     [ctw_pkg::ROW_W-1:0]      cursor_row,
  output logic     [ctw_pkg::ATTR_W-1:0]     current_attr,
  output logic                               range_error
);

  ctw_pkg::mem_req_t          mem_req;
  logic [ctw_pkg::CELL_W-1:0] rdata;

  ctw_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .op           (op),
    .char_code    (char_code),
    .fg_color     (fg_color),
    .bg_color     (bg_color),
    .cell_col     (cell_col),
    .cell_row     (cell_row),
    .rdata        (rdata),
    .mem_req      (mem_req),
    .busy         (busy),
    .done         (done),
    .cell_data    (cell_data),
    .cursor_col   (cursor_col),
    .cursor_row   (cursor_row),
    .current_attr (current_attr),
    .range_error  (range_error)
  );

  ctw_cell_ram u_ram (
    .clk   (clk),
    .req   (mem_req),
    .rdata (rdata)
  );

endmodule

`default_nettype wire

>>> rtl/core/ctw_cell_ram.sv
// ----------------------------------------------------------------------------
// ctw_cell_ram: character cell store
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ctw_cell_ram (
  input  wire logic                          clk,
  input  wire ctw_pkg::mem_req_t             req,
  output logic     [ctw_pkg::CELL_W-1:0]     rdata
);

  logic [ctw_pkg::CELL_W-1:0] mem [ctw_pkg::CELL_COUNT];

  // Write port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/ctw_ctrl.sv
// ----------------------------------------------------------------------------
// ctw_ctrl: console controller
// Holds cursor and attribute, executes one operation at a time and drives the
// cell memory, including the scroll copy and the clear sweep.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ctw_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [ctw_pkg::OP_W-1:0]      op,
  input  wire logic [ctw_pkg::CHAR_W-1:0]    char_code,
  input  wire logic [ctw_pkg::COLR_W-1:0]    fg_color,
  input  wire logic [ctw_pkg::COLR_W-1:0]    bg_color,
  input  wire logic [ctw_pkg::COL_W-1:0]     cell_col,
  input  wire logic [ctw_pkg::ROW_W-1:0]     cell_row,
  input  wire logic [ctw_pkg::CELL_W-1:0]    rdata,
  output ctw_pkg::mem_req_t                  mem_req,
  output logic                               busy,
  output logic                               done,
  output logic     [ctw_pkg::CELL_W-1:0]     cell_data,
  output logic     [ctw_pkg::COL_W-1:0]      cursor_col,
  output logic     [ctw_pkg::ROW_W-1:0]      cursor_row,
  output logic     [ctw_pkg::ATTR_W-1:0]     current_attr,
  output logic                               range_error
);

  ctw_pkg::state_t state, state_next;

  logic [ctw_pkg::CNT_W-1:0]  cnt, cnt_next, cnt_m1;
  logic [ctw_pkg::COL_W-1:0]  cursor_x, cursor_x_next;
  logic [ctw_pkg::ROW_W-1:0]  cursor_y, cursor_y_next;
  logic [ctw_pkg::ATTR_W-1:0] attr, attr_next;
  logic                       done_next;
  logic [ctw_pkg::CELL_W-1:0] cell_data_next;
  logic                       err, err_next;

  // Latched request
  logic [ctw_pkg::OP_W-1:0]   op_q;
  logic [ctw_pkg::CHAR_W-1:0] char_q;
  logic [ctw_pkg::COLR_W-1:0] fg_q;
  logic [ctw_pkg::COLR_W-1:0] bg_q;
  logic [ctw_pkg::COL_W-1:0]  col_q;
  logic [ctw_pkg::ROW_W-1:0]  row_q;

  // Decode of the latched request
  logic                        accept;
  logic                        on_screen;
  logic                        is_newline;
  logic                        wrap;
  logic                        need_scroll;
  logic                        go_read;
  logic                        go_clear;
  logic [ctw_pkg::COL_W:0]     x_inc;
  logic [ctw_pkg::ROW_W:0]     y_inc;
  logic [ctw_pkg::ROW_W-1:0]   addr_row;
  logic [ctw_pkg::COL_W-1:0]   addr_col;
  logic [ctw_pkg::ADDR_W-1:0]  exec_addr;
  logic                        scroll_end;
  logic                        clear_end;

  assign accept = start && (state == ctw_pkg::ST_IDLE);
  assign cnt_m1 = cnt - ctw_pkg::CNT_W'(1);

  // Decode operation and cursor motion
  always_comb begin
    on_screen   = ({1'b0, col_q} < ctw_pkg::COLUMNS_C) && ({1'b0, row_q} < ctw_pkg::ROWS_C);
    is_newline  = (char_q == ctw_pkg::NEWLINE_CODE);
    x_inc       = {1'b0, cursor_x} + (ctw_pkg::COL_W + 1)'(1);
    y_inc       = {1'b0, cursor_y} + (ctw_pkg::ROW_W + 1)'(1);
    wrap        = is_newline || (x_inc >= ctw_pkg::COLUMNS_C);
    need_scroll = (op_q == ctw_pkg::OP_WRITE_CHAR) && wrap && (y_inc >= ctw_pkg::ROWS_C);
    go_read     = (op_q == ctw_pkg::OP_READ_CELL) && on_screen;
    go_clear    = (op_q == ctw_pkg::OP_CLEAR);
    addr_row    = (op_q == ctw_pkg::OP_READ_CELL) ? row_q : cursor_y;
    addr_col    = (op_q == ctw_pkg::OP_READ_CELL) ? col_q : cursor_x;
    exec_addr   = ctw_pkg::ADDR_W'(ctw_pkg::ADDR_W'(addr_row) *
                  ctw_pkg::ADDR_W'(ctw_pkg::COLUMNS) + ctw_pkg::ADDR_W'(addr_col));
    scroll_end  = (cnt == ctw_pkg::CNT_W'(ctw_pkg::CELL_COUNT));
    clear_end   = (cnt == ctw_pkg::CNT_W'(ctw_pkg::CELL_COUNT - 1));
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ctw_pkg::ST_INIT: begin
        if (clear_end) state_next = ctw_pkg::ST_IDLE;
      end
      ctw_pkg::ST_IDLE: begin
        if (accept) state_next = ctw_pkg::ST_EXEC;
      end
      ctw_pkg::ST_EXEC: begin
        priority if (need_scroll) state_next = ctw_pkg::ST_SCROLL;
        else if (go_clear)        state_next = ctw_pkg::ST_CLEAR;
        else if (go_read)         state_next = ctw_pkg::ST_RDWAIT;
        else                      state_next = ctw_pkg::ST_IDLE;
      end
      ctw_pkg::ST_RDWAIT: begin
        state_next = ctw_pkg::ST_IDLE;
      end
      ctw_pkg::ST_SCROLL: begin
        if (scroll_end) state_next = ctw_pkg::ST_IDLE;
      end
      ctw_pkg::ST_CLEAR: begin
        if (clear_end) state_next = ctw_pkg::ST_IDLE;
      end
      default: state_next = ctw_pkg::ST_IDLE;
    endcase
  end

  // Memory requests and result
  always_comb begin
    mem_req        = '0;
    done_next      = 1'b0;
    cell_data_next = cell_data;
    err_next       = err;
    unique case (state)
      ctw_pkg::ST_INIT, ctw_pkg::ST_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = cnt[ctw_pkg::ADDR_W-1:0];
        mem_req.wdata = ctw_pkg::BLANK_CELL;
        done_next     = (state == ctw_pkg::ST_CLEAR) && clear_end;
      end
      ctw_pkg::ST_EXEC: begin
        cell_data_next = '0;
        err_next       = ((op_q == ctw_pkg::OP_SET_CURSOR) ||
                          (op_q == ctw_pkg::OP_READ_CELL)) && !on_screen;
        mem_req.waddr  = exec_addr;
        mem_req.wdata  = {attr, char_q};
        mem_req.we     = (op_q == ctw_pkg::OP_WRITE_CHAR) && !is_newline;
        mem_req.raddr  = exec_addr;
        mem_req.re     = go_read;
        done_next      = !need_scroll && !go_clear && !go_read;
      end
      ctw_pkg::ST_RDWAIT: begin
        cell_data_next = rdata;
        done_next      = 1'b1;
      end
      ctw_pkg::ST_SCROLL: begin
        // read one row ahead, write the word read last cycle one row up, blank the last row
        mem_req.re    = (cnt < ctw_pkg::CNT_W'(ctw_pkg::COPY_COUNT));
        mem_req.raddr = ctw_pkg::ADDR_W'(cnt + ctw_pkg::CNT_W'(ctw_pkg::COLUMNS));
        mem_req.we    = (cnt != '0);
        mem_req.waddr = cnt_m1[ctw_pkg::ADDR_W-1:0];
        mem_req.wdata = (cnt_m1 < ctw_pkg::CNT_W'(ctw_pkg::COPY_COUNT)) ?
                        rdata : {attr, ctw_pkg::BLANK_CHAR};
        done_next     = scroll_end;
      end
      default: begin
        mem_req = '0;
      end
    endcase
  end

  // Cursor, attribute and sweep counter updates
  always_comb begin
    cursor_x_next = cursor_x;
    cursor_y_next = cursor_y;
    attr_next     = attr;
    cnt_next      = cnt;
    unique case (state)
      ctw_pkg::ST_INIT, ctw_pkg::ST_CLEAR, ctw_pkg::ST_SCROLL: begin
        cnt_next = cnt + ctw_pkg::CNT_W'(1);
      end
      ctw_pkg::ST_EXEC: begin
        cnt_next = '0;
        unique case (op_q)
          ctw_pkg::OP_WRITE_CHAR: begin
            if (wrap) begin
              cursor_x_next = '0;
              cursor_y_next = (y_inc >= ctw_pkg::ROWS_C) ? ctw_pkg::LAST_ROW
                                                         : y_inc[ctw_pkg::ROW_W-1:0];
            end else begin
              cursor_x_next = x_inc[ctw_pkg::COL_W-1:0];
            end
          end
          ctw_pkg::OP_SET_CURSOR: begin
            if (on_screen) begin
              cursor_x_next = col_q;
              cursor_y_next = row_q;
            end
          end
          ctw_pkg::OP_CLEAR:     attr_next = ctw_pkg::DEFAULT_ATTR;
          ctw_pkg::OP_SET_COLOR: attr_next = {bg_q, fg_q};
          default: begin
            attr_next = attr;
          end
        endcase
      end
      default: begin
        cnt_next = cnt;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ctw_pkg::ST_INIT;
      cnt      <= '0;
      done     <= 1'b0;
      cursor_x <= '0;
      cursor_y <= '0;
      attr     <= ctw_pkg::DEFAULT_ATTR;
    end else begin
      state    <= state_next;
      cnt      <= cnt_next;
      done     <= done_next;
      cursor_x <= cursor_x_next;
      cursor_y <= cursor_y_next;
      attr     <= attr_next;
    end
  end

  // Payload registers: hold the request on transfer, hold the result fields
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q   <= op;
      char_q <= char_code;
      fg_q   <= fg_color;
      bg_q   <= bg_color;
      col_q  <= cell_col;
      row_q  <= cell_row;
    end
    cell_data <= cell_data_next;
    err       <= err_next;
  end

  assign busy         = (state != ctw_pkg::ST_IDLE);
  assign cursor_col   = cursor_x;
  assign cursor_row   = cursor_y;
  assign current_attr = attr;
  assign range_error  = err;

endmodule

`default_nettype wire

>>> rtl/core/ctw_checker.sv
// ----------------------------------------------------------------------------
// ctw_checker: port-level checks of the text console writer
// Watches transfers, result strobes and cursor behavior at the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ctw_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          start,
  input wire logic                          busy,
  input wire logic                          done,
  input wire logic [ctw_pkg::CELL_W-1:0]    cell_data,
  input wire logic [ctw_pkg::COL_W-1:0]     cursor_col,
  input wire logic [ctw_pkg::ROW_W-1:0]     cursor_row,
  input wire logic                          range_error
);

  // A transfer always leaves the block busy in the next cycle
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after transfer");

  // A result only ends a busy period, one strobe per request
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(busy) && !busy))
    else $error("result strobe outside a busy period");

  // Off-screen requests never report cell data
  a_error_no_data: assert property (@(posedge clk) disable iff (rst)
    (done && range_error) |-> (cell_data == '0))
    else $error("range error with nonzero cell data");

  // Cursor holds while idle with no transfer, and stays on screen
  a_cursor_idle: assert property (@(posedge clk) disable iff (rst)
    (!busy && !start) |=> ($stable(cursor_col) && $stable(cursor_row)
      && ({1'b0, cursor_col} < ctw_pkg::COLUMNS_C)
      && ({1'b0, cursor_row} < ctw_pkg::ROWS_C)))
    else $error("cursor moved or off screen while idle");

endmodule

bind text_console_writer_top ctw_checker u_ctw_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .cell_data   (cell_data),
  .cursor_col  (cursor_col),
  .cursor_row  (cursor_row),
  .range_error (range_error)
);

`default_nettype wire
